// ----- design/fwa_pkg.sv -----
package fwa_pkg;

  localparam int MAX_FRAMES  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int POS_W       = 10;
  localparam int LEN_W       = 11;
  localparam int SUM_W       = 28;
  localparam int AVG_W       = 17;
  localparam int PKT_W       = 16;
  localparam int COEF_W      = 17;
  localparam int DIV_W       = 41;
  localparam int DIV_CNT_W   = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [31:0] C1      = 32'd1686629713;
  localparam logic [31:0] C3      = 32'd693598668;
  localparam logic [31:0] C5      = 32'd85569305;
  localparam logic [31:0] C7      = 32'd5026995;
  localparam logic [31:0] C9      = 32'd172272;
  localparam logic [31:0] C11     = 32'd3864;
  localparam logic [31:0] Q30_ONE = 32'd1073741824;
  localparam logic [31:0] HAM_A   = 32'd85899346;
  localparam logic [31:0] HAM_B   = 32'd987842478;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO   = 2'd2;

  typedef enum logic [1:0] {
    WIN_RECT, WIN_HANN, WIN_HAMMING, WIN_SINE
  } win_e;

  typedef enum logic [3:0] {
    STEP_X2, STEP_R9, STEP_R7, STEP_R5, STEP_R3, STEP_R1,
    STEP_S, STEP_S2, STEP_HAM, STEP_WIN
  } step_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIVX_GO, ST_DIVX_WAIT, ST_MUL, ST_CHK, ST_DIVA_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic  accept;
    logic  div_go;
    logic  div_avg;
    logic  mul_go;
    logic  mul_wb;
    step_e step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic rect;
    logic last;
    logic div_busy;
  } sts_t;

endpackage

// ----- design/fwa_div.sv -----
module fwa_div
  import fwa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W:0]       trial;
  logic [LEN_W:0]       diff;
  logic                 ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = trial >= {1'b0, divisor_i};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (go_i) begin
      cnt_d = DIV_CNT_W'(DIV_W);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;

endmodule

// ----- design/fwa_datapath.sv -----
module fwa_datapath
  import fwa_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [LEN_W-1:0]            cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic signed [SAMPLE_BITS-1:0] play_left_o,
  output logic signed [SAMPLE_BITS-1:0] play_right_o,
  output logic signed [SAMPLE_BITS-1:0] windowed_left_o,
  output logic signed [SAMPLE_BITS-1:0] windowed_right_o,
  output logic [POS_W-1:0]            frame_position_o,
  output logic [PKT_W-1:0]            packet_number_o,
  output logic signed [AVG_W-1:0]     average_amplitude_o,
  output logic                        last_of_packet_o
);

  win_e             win_q;
  logic [LEN_W-1:0] flen_q;
  logic             mono_q;

  logic [POS_W-1:0]        pos_q;
  logic [PKT_W-1:0]        pkt_q;
  logic signed [SUM_W-1:0] sum_q;

  logic signed [SAMPLE_BITS-1:0] l_q, r_q, wl_q, wr_q;
  logic [POS_W-1:0]        u_q, lm1_q, ipos_q;
  logic [LEN_W-1:0]        len_q;
  logic [PKT_W-1:0]        ipkt_q;
  logic                    last_q;
  logic signed [SUM_W-1:0] tot_q;

  logic [63:0] p_q;
  logic [31:0] x2_q, r_q2, s_q, s2_q;
  logic [COEF_W-1:0] w_q;
  logic signed [33:0] pl_q, pr_q;

  logic [LEN_W-1:0] len_c;
  logic [POS_W-1:0] lm1_c, n_c, rest_c, u_c;
  logic             last_c;
  logic signed [SAMPLE_BITS-1:0] rin_c;
  logic signed [SUM_W-1:0] sum_new;

  logic [DIV_W-1:0] dividend, quot;
  logic [LEN_W-1:0] divisor;
  logic [SUM_W-1:0] mag;
  logic             div_busy;

  logic [31:0] x_c, opa, opb, p_sh, p_rnd, h_c, wsel;
  logic [32:0] wsum;
  logic [COEF_W:0] wround;
  logic [COEF_W-1:0] w_c;
  logic signed [33:0] tl, tr, ql, qr;
  logic signed [SAMPLE_BITS-1:0] cl, cr;
  logic [AVG_W-1:0] avg_c;

  function automatic logic signed [SAMPLE_BITS-1:0] sat16(input logic signed [33:0] v);
    logic signed [SAMPLE_BITS-1:0] res;
    if (v > 34'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  always_comb begin
    if (flen_q < LEN_W'(2)) begin
      len_c = LEN_W'(2);
    end else if (flen_q > LEN_W'(MAX_FRAMES)) begin
      len_c = LEN_W'(MAX_FRAMES);
    end else begin
      len_c = flen_q;
    end
    lm1_c   = POS_W'(len_c - 1'b1);
    last_c  = pos_q >= lm1_c;
    n_c     = last_c ? lm1_c : pos_q;
    rest_c  = lm1_c - n_c;
    u_c     = (n_c < rest_c) ? n_c : rest_c;
    rin_c   = mono_q ? left_sample_i : right_sample_i;
    sum_new = sum_q + SUM_W'(left_sample_i) + SUM_W'(rin_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WIN_RECT;
      flen_q <= LEN_W'(256);
      mono_q <= 1'b0;
      pos_q  <= '0;
      pkt_q  <= '0;
      sum_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WINDOW: win_q  <= win_e'(cfg_data_i[1:0]);
          CFG_LENGTH: flen_q <= cfg_data_i;
          CFG_MONO:   mono_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (last_c) begin
          pos_q <= '0;
          pkt_q <= pkt_q + 1'b1;
          sum_q <= '0;
        end else begin
          pos_q <= pos_q + 1'b1;
          sum_q <= sum_new;
        end
      end
    end
  end

  assign mag      = tot_q[SUM_W-1] ? SUM_W'(-tot_q) : SUM_W'(tot_q);
  assign dividend = cmd_i.div_avg ? DIV_W'(mag) : {u_q, 31'b0};
  assign divisor  = cmd_i.div_avg ? len_q : {1'b0, lm1_q};

  fwa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_comb begin
    x_c = (quot[30:0] > Q30_ONE[30:0]) ? Q30_ONE : {1'b0, quot[30:0]};
    case (cmd_i.step)
      STEP_X2:  begin opa = x_c;   opb = x_c;  end
      STEP_R9:  begin opa = x2_q;  opb = C11;  end
      STEP_S:   begin opa = x_c;   opb = r_q2; end
      STEP_S2:  begin opa = s_q;   opb = s_q;  end
      STEP_HAM: begin opa = HAM_B; opb = s2_q; end
      default:  begin opa = x2_q;  opb = r_q2; end
    endcase
    p_sh  = p_q[61:30];
    p_rnd = 32'((p_q + 64'd536870912) >> 30);
    h_c   = HAM_A + p_rnd;
    case (win_q)
      WIN_HANN:    wsel = s2_q;
      WIN_HAMMING: wsel = h_c;
      default:     wsel = s_q;
    endcase
    wsum   = {1'b0, wsel} + 33'd16384;
    wround = wsum[32:15] > 18'd32768 ? 18'd32768 : wsum[32:15];
    w_c    = wround[COEF_W-1:0];
    tl     = pl_q + 34'sd16384;
    tr     = pr_q + 34'sd16384;
    ql     = tl >>> 15;
    qr     = tr >>> 15;
    cl     = sat16(ql);
    cr     = sat16(qr);
    avg_c  = tot_q[SUM_W-1] ? AVG_W'(-quot[AVG_W-1:0]) : quot[AVG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      l_q    <= left_sample_i;
      r_q    <= rin_c;
      u_q    <= u_c;
      lm1_q  <= lm1_c;
      len_q  <= len_c;
      ipos_q <= pos_q;
      ipkt_q <= pkt_q;
      last_q <= last_c;
      tot_q  <= sum_new;
    end
    if (cmd_i.mul_go) begin
      p_q  <= 64'(opa) * 64'(opb);
      pl_q <= 34'(l_q) * 34'($signed({1'b0, w_q}));
      pr_q <= 34'(r_q) * 34'($signed({1'b0, w_q}));
    end
    if (cmd_i.mul_wb) begin
      case (cmd_i.step)
        STEP_X2:  x2_q <= p_sh;
        STEP_R9:  r_q2 <= C9 - p_sh;
        STEP_R7:  r_q2 <= C7 - p_sh;
        STEP_R5:  r_q2 <= C5 - p_sh;
        STEP_R3:  r_q2 <= C3 - p_sh;
        STEP_R1:  r_q2 <= C1 - p_sh;
        STEP_S:   s_q  <= (p_sh > Q30_ONE) ? Q30_ONE : p_sh;
        STEP_S2:  s2_q <= p_rnd;
        STEP_HAM: w_q  <= w_c;
        STEP_WIN: begin
          wl_q <= cl;
          wr_q <= cr;
        end
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      play_left_o         <= l_q;
      play_right_o        <= r_q;
      windowed_left_o     <= (win_q == WIN_RECT) ? l_q : wl_q;
      windowed_right_o    <= (win_q == WIN_RECT) ? r_q : wr_q;
      frame_position_o    <= ipos_q;
      packet_number_o     <= ipkt_q;
      average_amplitude_o <= last_q ? avg_c : '0;
      last_of_packet_o    <= last_q;
    end
  end

  assign sts_o.rect     = win_q == WIN_RECT;
  assign sts_o.last     = last_q;
  assign sts_o.div_busy = div_busy;

endmodule

// ----- design/fwa_ctrl.sv -----
module fwa_ctrl
  import fwa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  step_e  step_q;
  logic   phase_q;
  logic   out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = sts_i.rect ? ST_CHK : ST_DIVX_GO;
      ST_DIVX_GO:   state_d = ST_DIVX_WAIT;
      ST_DIVX_WAIT: if (!sts_i.div_busy) state_d = ST_MUL;
      ST_MUL:       if (phase_q && step_q == STEP_WIN) state_d = ST_CHK;
      ST_CHK:       state_d = sts_i.last ? ST_DIVA_WAIT : ST_OUT;
      ST_DIVA_WAIT: if (!sts_i.div_busy) state_d = ST_OUT;
      ST_OUT:       if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.step     = step_q;
    cmd_o.div_avg  = state_q == ST_CHK || state_q == ST_DIVA_WAIT;
    case (state_q)
      ST_IDLE:    cmd_o.accept   = in_valid_i;
      ST_DIVX_GO: cmd_o.div_go   = 1'b1;
      ST_MUL: begin
        cmd_o.mul_go = !phase_q;
        cmd_o.mul_wb = phase_q;
      end
      ST_CHK:     cmd_o.div_go   = sts_i.last;
      ST_OUT:     cmd_o.out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_X2;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != ST_MUL) begin
        step_q  <= STEP_X2;
        phase_q <= 1'b0;
      end else begin
        phase_q <= !phase_q;
        if (phase_q && step_q != STEP_WIN) begin
          step_q <= step_e'(step_q + 1'b1);
        end
      end
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/frame_window_and_average.sv -----
// Channel  Direction  Handshake               Content
// cfg      in         cfg_we_i                window type, frame length, mono mode
// in       in         in_valid_i, in_stall_o  left and right sample
// out      out        out_valid_o, out_stall_i playback, windowed, position, average
//
// A rectangular word goes from acceptance to the result check and output; a windowed
// word first runs the serial divider for the window phase, then the multiply sequence
// for the sine polynomial and the window scaling. The last word of a packet adds the
// averaging divide on the same divider. Reset clears all counters and loads the
// register defaults. A held result stalls only the final transfer.
module frame_window_and_average
  import fwa_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [LEN_W-1:0]              cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] play_left_o,
  output logic signed [SAMPLE_BITS-1:0] play_right_o,
  output logic signed [SAMPLE_BITS-1:0] windowed_left_o,
  output logic signed [SAMPLE_BITS-1:0] windowed_right_o,
  output logic [POS_W-1:0]              frame_position_o,
  output logic [PKT_W-1:0]              packet_number_o,
  output logic signed [AVG_W-1:0]       average_amplitude_o,
  output logic                          last_of_packet_o
);

  cmd_t cmd;
  sts_t sts;

  fwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fwa_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .left_sample_i       (left_sample_i),
    .right_sample_i      (right_sample_i),
    .play_left_o         (play_left_o),
    .play_right_o        (play_right_o),
    .windowed_left_o     (windowed_left_o),
    .windowed_right_o    (windowed_right_o),
    .frame_position_o    (frame_position_o),
    .packet_number_o     (packet_number_o),
    .average_amplitude_o (average_amplitude_o),
    .last_of_packet_o    (last_of_packet_o)
  );

endmodule

// ----- design/fwa_checker.sv -----
module fwa_checker
  import fwa_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] play_left_o,
  input logic signed [SAMPLE_BITS-1:0] windowed_left_o,
  input logic [POS_W-1:0]              frame_position_o,
  input logic signed [AVG_W-1:0]       average_amplitude_o,
  input logic                          last_of_packet_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(play_left_o) && $stable(windowed_left_o)
      && $stable(frame_position_o) && $stable(last_of_packet_o))
    else $error("stalled result word changed");

  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_packet_o |-> average_amplitude_o == '0)
    else $error("average reported outside the last frame");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new word taken while one is in progress");

endmodule

bind frame_window_and_average fwa_checker u_fwa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .play_left_o         (play_left_o),
  .windowed_left_o     (windowed_left_o),
  .frame_position_o    (frame_position_o),
  .average_amplitude_o (average_amplitude_o),
  .last_of_packet_o    (last_of_packet_o)
);

// ----- test/frame_window_and_average_checker.sv -----
module frame_window_and_average_checker
  import fwa_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [LEN_W-1:0]              cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] play_left_o,
  input  logic signed [SAMPLE_BITS-1:0] play_right_o,
  input  logic signed [SAMPLE_BITS-1:0] windowed_left_o,
  input  logic signed [SAMPLE_BITS-1:0] windowed_right_o,
  input  logic [POS_W-1:0]              frame_position_o,
  input  logic [PKT_W-1:0]              packet_number_o,
  input  logic signed [AVG_W-1:0]       average_amplitude_o,
  input  logic                          last_of_packet_o,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] pl, pr, wl, wr;
    logic [9:0]  pos;
    logic [15:0] pkt;
    logic [16:0] avg;
    logic        last;
  } frame_result_t;

  win_e          shape;
  logic [10:0]   length_reg;
  logic          mono;
  logic [9:0]    position;
  longint        packet_sum;
  logic [15:0]   packet_index;
  frame_result_t expected_frames[$];

  function automatic longint half_sine(longint n, longint lm1);
    longint u, x, x2, r, s;
    u = (n < lm1 - n) ? n : lm1 - n;
    x = ((u * 2) << 30) / lm1;
    if (x > Q30_ONE) x = Q30_ONE;
    x2 = (x * x) >>> 30;
    r = C11;
    r = C9 - ((x2 * r) >>> 30);
    r = C7 - ((x2 * r) >>> 30);
    r = C5 - ((x2 * r) >>> 30);
    r = C3 - ((x2 * r) >>> 30);
    r = C1 - ((x2 * r) >>> 30);
    s = (x * r) >>> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    return s;
  endfunction

  function automatic longint coefficient(longint n, longint lm1);
    longint s, s2, w;
    s = half_sine(n, lm1);
    s2 = (s * s + (longint'(1) << 29)) >>> 30;
    if (shape == WIN_HANN) w = (s2 + 16384) >>> 15;
    else if (shape == WIN_HAMMING)
      w = (HAM_A + ((HAM_B * s2 + (longint'(1) << 29)) >>> 30) + 16384) >>> 15;
    else w = (s + 16384) >>> 15;
    if (w > 32768) w = 32768;
    return w;
  endfunction

  function automatic logic [15:0] scale(longint x, longint w);
    longint q;
    q = (x * w + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic frame_result_t predict_frame(longint l, longint r_in);
    frame_result_t f;
    longint len, lm1, r, n, w, a;
    len = length_reg;
    if (len < 2) len = 2;
    if (len > MAX_FRAMES) len = MAX_FRAMES;
    lm1 = len - 1;
    r = mono ? l : r_in;
    n = (position > lm1) ? lm1 : position;
    f.pl = l[15:0];
    f.pr = r[15:0];
    if (shape == WIN_RECT) begin
      f.wl = l[15:0];
      f.wr = r[15:0];
    end else begin
      w = coefficient(n, lm1);
      f.wl = scale(l, w);
      f.wr = scale(r, w);
    end
    packet_sum += l + r;
    f.last = position >= lm1;
    f.pos = position;
    f.pkt = packet_index;
    f.avg = '0;
    if (f.last) begin
      a = (packet_sum < 0) ? -((-packet_sum) / len) : packet_sum / len;
      f.avg = a[16:0];
      packet_sum = 0;
      position = '0;
      packet_index++;
    end else begin
      position++;
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t e;
    if (!rst_ni) begin
      shape <= WIN_RECT;
      length_reg <= 11'd256;
      mono <= 1'b0;
      position = '0;
      packet_sum = 0;
      packet_index = '0;
      fail_count = 0;
      expected_frames.delete();
      pending_count = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WINDOW) shape <= win_e'(cfg_data_i[1:0]);
        else if (cfg_index_i == CFG_LENGTH) length_reg <= cfg_data_i;
        else if (cfg_index_i == CFG_MONO) mono <= cfg_data_i[0];
      end
      if (in_valid_i && !in_stall_o)
        expected_frames.push_back(predict_frame(left_sample_i, right_sample_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          e = expected_frames.pop_front();
          if (play_left_o !== e.pl) report_mismatch("play_left", play_left_o, $signed(e.pl));
          if (play_right_o !== e.pr)
            report_mismatch("play_right", play_right_o, $signed(e.pr));
          if (windowed_left_o !== e.wl)
            report_mismatch("windowed_left", windowed_left_o, $signed(e.wl));
          if (windowed_right_o !== e.wr)
            report_mismatch("windowed_right", windowed_right_o, $signed(e.wr));
          if (frame_position_o !== e.pos)
            report_mismatch("frame_position", frame_position_o, e.pos);
          if (packet_number_o !== e.pkt)
            report_mismatch("packet_number", packet_number_o, e.pkt);
          if (average_amplitude_o !== e.avg)
            report_mismatch("average_amplitude", average_amplitude_o, $signed(e.avg));
          if (last_of_packet_o !== e.last)
            report_mismatch("last_of_packet", last_of_packet_o, e.last);
        end
      end
      pending_count = expected_frames.size();
    end
  end
endmodule

// ----- test/frame_window_and_average_test.sv -----
module frame_window_and_average_test;
  import fwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [LEN_W-1:0]              cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] left_sample_i = '0;
  logic signed [SAMPLE_BITS-1:0] right_sample_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] play_left_o, play_right_o;
  logic signed [SAMPLE_BITS-1:0] windowed_left_o, windowed_right_o;
  logic [POS_W-1:0]              frame_position_o;
  logic [PKT_W-1:0]              packet_number_o;
  logic signed [AVG_W-1:0]       average_amplitude_o;
  logic                          last_of_packet_o;
  int                            fail_count, pending_count;
  int                            idle_cycles;
  bit                            hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  frame_window_and_average u_dut (.*);
  frame_window_and_average_checker u_checker (.*);

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(logic [15:0] l, logic [15:0] r, bit gap);
    int pause;
    left_sample_i <= l;
    right_sample_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (gap) begin
      pause = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
  endtask

  task automatic drain;
    while (pending_count != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic random_block(int count, bit full_scale);
    int burst;
    logic [15:0] l, r;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      l = full_scale ? 16'($urandom) : 16'($signed($urandom_range(0, 600)) - 300);
      r = ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom);
      send_word(l, r, burst == 0);
    end
    in_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 3) == 0) && ($time % 4000 > 1500);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("frame_window_and_average verification failed");
      $finish;
    end
  end

  initial begin
    int lengths[7];
    lengths = '{2, 3, 5, 16, 1, 1024, 2047};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_word(16'h7FFF, 16'h8000, 1'b0);
    send_word(16'h8000, 16'h7FFF, 1'b0);
    send_word(16'h0000, 16'hFFFF, 1'b1);
    in_valid_i <= 1'b0;
    drain();
    write_register(CFG_LENGTH, 11'd5);
    for (int t = 0; t < 4; t++) begin
      write_register(CFG_WINDOW, LEN_W'(t));
      write_register(CFG_MONO, LEN_W'(t & 1));
      send_word(16'h7FFF, 16'h8000, 1'b0);
      send_word(16'h8000, 16'h8000, 1'b0);
      send_word(16'h7FFF, 16'h7FFF, 1'b0);
      send_word(16'h0001, 16'hFFFF, 1'b1);
      in_valid_i <= 1'b0;
      drain();
    end
    write_register(CFG_LENGTH, 11'd3);
    write_register(CFG_MONO, 11'd0);
    send_word(16'h1234, 16'h4321, 1'b0);
    in_valid_i <= 1'b0;
    drain();
    write_register(CFG_LENGTH, 11'd0);
    write_register(CFG_WINDOW, 11'(WIN_HANN));
    send_word(16'h7FFF, 16'h7FFF, 1'b1);
    in_valid_i <= 1'b0;
    drain();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_block(6, 1'b1);
    join
    drain();
    for (int p = 0; p < 14; p++) begin
      write_register(CFG_WINDOW, LEN_W'($urandom_range(0, 3)));
      write_register(CFG_MONO, LEN_W'($urandom_range(0, 1)));
      write_register(CFG_LENGTH, LEN_W'(lengths[p % 7]));
      random_block((p % 7 == 5 || p % 7 == 6) ? 90 : 25, p[0]);
      drain();
    end
    if (fail_count == 0) begin
      $display("frame_window_and_average verification clean");
    end else begin
      $display("frame_window_and_average verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/fwa_pkg.sv
design/fwa_div.sv
design/fwa_datapath.sv
design/fwa_ctrl.sv
design/frame_window_and_average.sv
design/fwa_checker.sv
test/frame_window_and_average_checker.sv
test/frame_window_and_average_test.sv
